[design/ddwrl_pkg.sv]
package ddwrl_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAX_SPEED      = 3'd0,
      CSR_MAX_TURN_RATE  = 3'd1,
      CSR_SPEED_PER_TURN = 3'd2,
      CSR_HALF_TRACK     = 3'd3,
      CSR_INVERSE_RADIUS = 3'd4
   } csr_index_type;

   localparam logic [14:0] MaxSpeedReset     = 15'd4096;
   localparam logic [14:0] MaxTurnRateReset  = 15'd16384;
   localparam logic [15:0] SpeedPerTurnReset = 16'd16384;
   localparam logic [15:0] HalfTrackReset    = 16'd16384;
   localparam logic [15:0] InverseRadiusReset = 16'd5120;

   localparam logic signed [23:0] RateMax = 24'sh7FFFFF;
   localparam logic signed [23:0] RateMin = -24'sh800000;

   typedef struct packed {
      logic [14:0] max_speed;
      logic [14:0] max_turn_rate;
      logic [15:0] speed_per_turn;
      logic [15:0] half_track;
      logic [15:0] inverse_radius;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] speed_cmd;
      logic signed [15:0] turn_cmd;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [31:0] turn;
   } lim_type;

   typedef struct packed {
      logic signed [23:0] right_rate;
      logic signed [23:0] left_rate;
   } rsp_type;

endpackage

[design/ddwrl_limit.sv]
module ddwrl_limit (
   input  logic               clock,
   input  logic               reset,
   input  ddwrl_pkg::cfg_type cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ddwrl_pkg::req_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ddwrl_pkg::lim_type out_data
);
   import ddwrl_pkg::*;

   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   // stage 1: magnitudes and turn limit
   logic signed [15:0] spd1_ff, spd1_in, trn1_ff, trn1_in;
   logic [15:0]        av1_ff, av1_in, aw1_ff, aw1_in;
   logic               stop1_ff, stop1_in;
   logic signed [16:0] w17, wm17;

   // stage 2: products
   logic signed [15:0] spd2_ff;
   logic               stop2_ff;
   logic [30:0]        pa2_ff, pa2_in, pb2_ff, pb2_in;
   logic [29:0]        pc2_ff, pc2_in;
   logic [31:0]        pd2_ff, pd2_in;
   logic signed [32:0] tprod;
   logic signed [31:0] turn2_ff, turn2_in;

   // stage 3: select limited speed
   lim_type            lim3_ff, lim3_in;
   logic [31:0]        dsum;
   logic signed [16:0] mdiff;
   logic [14:0]        mag;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      spd1_in  = in_data.speed_cmd;
      trn1_in  = in_data.turn_cmd;
      av1_in   = in_data.speed_cmd[15] ? 16'(-in_data.speed_cmd) : 16'(in_data.speed_cmd);
      aw1_in   = in_data.turn_cmd[15] ? 16'(-in_data.turn_cmd) : 16'(in_data.turn_cmd);
      w17      = 17'(in_data.turn_cmd);
      wm17     = $signed({2'b00, cfg.max_turn_rate});
      stop1_in = (w17 >= wm17) || (w17 <= -wm17);
   end

   always_comb begin
      pa2_in   = 31'(av1_ff) * 31'(cfg.max_turn_rate);
      pb2_in   = 31'(aw1_ff) * 31'(cfg.max_speed);
      pc2_in   = 30'(cfg.max_speed) * 30'(cfg.max_turn_rate);
      pd2_in   = 32'(aw1_ff) * 32'(cfg.speed_per_turn) + 32'h8000;
      tprod    = 33'(trn1_ff) * $signed({17'd0, cfg.half_track});
      turn2_in = tprod[31:0];
   end

   always_comb begin
      dsum  = 32'(pa2_ff) + 32'(pb2_ff);
      mdiff = $signed({2'b00, cfg.max_speed}) - $signed({1'b0, pd2_ff[31:16]});
      mag   = mdiff[16] ? 15'd0 : mdiff[14:0];
      lim3_in.turn = turn2_ff;
      if (stop2_ff) begin
         lim3_in.speed = 16'sd0;
      end else if (dsum <= 32'(pc2_ff)) begin
         lim3_in.speed = spd2_ff;
      end else if (spd2_ff[15]) begin
         lim3_in.speed = -$signed({1'b0, mag});
      end else begin
         lim3_in.speed = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         spd1_ff  <= spd1_in;
         trn1_ff  <= trn1_in;
         av1_ff   <= av1_in;
         aw1_ff   <= aw1_in;
         stop1_ff <= stop1_in;
      end
      if (en2) begin
         spd2_ff  <= spd1_ff;
         stop2_ff <= stop1_ff;
         pa2_ff   <= pa2_in;
         pb2_ff   <= pb2_in;
         pc2_ff   <= pc2_in;
         pd2_ff   <= pd2_in;
         turn2_ff <= turn2_in;
      end
      if (en3) begin
         lim3_ff <= lim3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = lim3_ff;

endmodule

[design/ddwrl_mix.sv]
module ddwrl_mix (
   input  logic               clock,
   input  logic               reset,
   input  ddwrl_pkg::cfg_type cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ddwrl_pkg::lim_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ddwrl_pkg::rsp_type out_data
);
   import ddwrl_pkg::*;

   logic en4, en5, en6;
   logic v4_ff, v5_ff, v6_ff;

   logic signed [31:0] base;
   logic signed [32:0] sr4_ff, sr4_in, sl4_ff, sl4_in;
   logic signed [49:0] pr5_ff, pr5_in, pl5_ff, pl5_in;
   logic signed [49:0] ir50;
   rsp_type            rsp6_ff, rsp6_in;

   function automatic logic signed [23:0] round_sat(input logic signed [49:0] p);
      logic signed [49:0] r;
      logic signed [25:0] q;
      r = p + 50'sd8388608;
      q = r[49:24];
      if (q[25] == 1'b0 && q[24:23] != 2'b00) begin
         round_sat = RateMax;
      end else if (q[25] == 1'b1 && q[24:23] != 2'b11) begin
         round_sat = RateMin;
      end else begin
         round_sat = q[23:0];
      end
   endfunction

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   always_comb begin
      base    = {in_data.speed, 16'h0000};
      sr4_in  = 33'(base) + 33'(in_data.turn);
      sl4_in  = 33'(base) - 33'(in_data.turn);
      ir50    = $signed({34'd0, cfg.inverse_radius});
      pr5_in  = 50'(sr4_ff) * ir50;
      pl5_in  = 50'(sl4_ff) * ir50;
      rsp6_in.right_rate = round_sat(pr5_ff);
      rsp6_in.left_rate  = round_sat(pl5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         sr4_ff <= sr4_in;
         sl4_ff <= sl4_in;
      end
      if (en5) begin
         pr5_ff <= pr5_in;
         pl5_ff <= pl5_in;
      end
      if (en6) begin
         rsp6_ff <= rsp6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = rsp6_ff;

endmodule

[design/diff_drive_wheel_rate_limiter.sv]
// Throughput: one item per cycle while rsp_stall is low; six register stages (magnitudes, products,
// limit select, wheel sums, reciprocal multiply, round/saturate).
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults; csr writes are never stalled (csr_ready is tied high).
module diff_drive_wheel_rate_limiter (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  ddwrl_pkg::req_type                         req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output ddwrl_pkg::rsp_type                         rsp_data,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [ddwrl_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [ddwrl_pkg::CsrDataWidth-1:0]         csr_wdata
);
   import ddwrl_pkg::*;

   cfg_type cfg_ff;
   logic    lim_valid, lim_ready, in_ready;
   lim_type lim_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed      <= MaxSpeedReset;
         cfg_ff.max_turn_rate  <= MaxTurnRateReset;
         cfg_ff.speed_per_turn <= SpeedPerTurnReset;
         cfg_ff.half_track     <= HalfTrackReset;
         cfg_ff.inverse_radius <= InverseRadiusReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_SPEED:      cfg_ff.max_speed      <= csr_wdata[14:0];
            CSR_MAX_TURN_RATE:  cfg_ff.max_turn_rate  <= csr_wdata[14:0];
            CSR_SPEED_PER_TURN: cfg_ff.speed_per_turn <= csr_wdata;
            CSR_HALF_TRACK:     cfg_ff.half_track     <= csr_wdata;
            CSR_INVERSE_RADIUS: cfg_ff.inverse_radius <= csr_wdata;
            default: ;
         endcase
      end
   end

   ddwrl_limit u_limit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_data   (req_data),
      .out_valid (lim_valid),
      .out_ready (lim_ready),
      .out_data  (lim_data)
   );

   ddwrl_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (lim_valid),
      .in_ready  (lim_ready),
      .in_data   (lim_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !in_ready;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import ddwrl_pkg::*;

   localparam int IdleLimit = 2000;
   localparam int Phases = 12;
   localparam int ItemsPerPhase = 150;
   localparam logic [CsrIndexWidth-1:0] CsrFirstUnmapped =
      CsrIndexWidth'(CSR_INVERSE_RADIUS + 1);
   localparam logic [CsrIndexWidth-1:0] CsrLastIndex = '1;

   typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_type cmd;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0] value;
      bit given;
      rsp_type rates;
   } step_type;

   typedef struct {
      bit given;
      rsp_type rates;
   } listed_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   cfg_type limits;
   rsp_type pending_rates[$];
   listed_type listed_rates[$];
   step_type plan[$];
   int mismatches = 0;
   int idle_cycles = 0;

   diff_drive_wheel_rate_limiter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Q4.28 sum times Q8.8 reciprocal, round half up to Q12.12, saturate
   function automatic logic signed [23:0] wheel_rate(longint sum, longint inv_radius);
      longint q;
      q = (sum * inv_radius + (longint'(1) <<< 23)) >>> 24;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[23:0];
   endfunction

   function automatic rsp_type wheel_rates(req_type cmd, cfg_type c);
      longint v, w, vmax, wmax, slope, track, inv_radius, av, aw, vl, base, turn;
      rsp_type r;
      v = $signed(cmd.speed_cmd);
      w = $signed(cmd.turn_cmd);
      vmax = c.max_speed;
      wmax = c.max_turn_rate;
      slope = c.speed_per_turn;
      track = c.half_track;
      inv_radius = c.inverse_radius;
      av = v < 0 ? -v : v;
      aw = w < 0 ? -w : w;
      if (w >= wmax || w <= -wmax) begin
         vl = 0;
      end else if (av * wmax + aw * vmax <= vmax * wmax) begin
         vl = v;
      end else begin
         vl = vmax - ((aw * slope + 32768) >>> 16);
         if (vl < 0) vl = 0;
         if (v < 0) vl = -vl;
      end
      base = vl * 65536;
      turn = w * track;
      r.right_rate = wheel_rate(base + turn, inv_radius);
      r.left_rate = wheel_rate(base - turn, inv_radius);
      return r;
   endfunction

   function automatic step_type item_step(int v, int w, bit given = 1'b0, int right = 0,
                                          int left = 0);
      step_type s;
      s.kind = STEP_ITEM;
      s.cmd.speed_cmd = 16'(v);
      s.cmd.turn_cmd = 16'(w);
      s.index = '0;
      s.value = '0;
      s.given = given;
      s.rates.right_rate = 24'(right);
      s.rates.left_rate = 24'(left);
      return s;
   endfunction

   function automatic step_type write_step(logic [CsrIndexWidth-1:0] index,
                                           logic [CsrDataWidth-1:0] value);
      step_type s;
      s = item_step(0, 0);
      s.kind = STEP_WRITE;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   function automatic int pick_word(int top);
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 65535;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   function automatic int consistent_slope(int vmax, int wmax);
      longint q;
      if (wmax == 0) return $urandom_range(0, 65535);
      q = ((longint'(vmax) <<< 16) + wmax / 2) / wmax;
      return q > 65535 ? 65535 : int'(q);
   endfunction

   function automatic int clamp16(int x);
      return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
   endfunction

   function automatic req_type random_cmd(int vmax, int wmax);
      int v, w;
      req_type cmd;
      v = int'($urandom_range(0, 65535)) - 32768;
      w = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4, 5, 6: begin
            v = int'($urandom_range(0, 2 * vmax)) - vmax;
            w = int'($urandom_range(0, 2 * wmax + 4)) - wmax - 2;
         end
         7: begin
            w = ($urandom_range(0, 1) ? wmax : -wmax) + int'($urandom_range(0, 2)) - 1;
         end
         default: begin
            v = ($urandom_range(0, 1) ? vmax : -vmax) + int'($urandom_range(0, 2)) - 1;
            w = int'($urandom_range(0, 2 * wmax)) - wmax;
         end
      endcase
      cmd.speed_cmd = 16'(clamp16(v));
      cmd.turn_cmd = 16'(clamp16(w));
      return cmd;
   endfunction

   function automatic int gap_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 19);
      if (r < 13) return 0;
      if (r < 19) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_cmd(req_type cmd, bit given, rsp_type rates);
      listed_rates.push_back('{given, rates});
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         req_data <= req_type'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rates.size() != 0);
      @(posedge clock);
   endtask

   // csr_valid stays high across a batch; caller lowers it
   task automatic write_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   initial begin : result_sink
      int hold;
      rsp_stall <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  rsp_stall <= 1'b0;
                  hold = $urandom_range(0, 30);
               end
               4, 5, 6, 7: begin
                  rsp_stall <= 1'b1;
                  hold = $urandom_range(0, 2);
               end
               8: begin
                  rsp_stall <= 1'b1;
                  hold = $urandom_range(8, 40);
               end
               default: begin
                  rsp_stall <= 1'b0;
                  hold = $urandom_range(100, 300);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      listed_type listed;
      if (reset) begin
         limits.max_speed = MaxSpeedReset;
         limits.max_turn_rate = MaxTurnRateReset;
         limits.speed_per_turn = SpeedPerTurnReset;
         limits.half_track = HalfTrackReset;
         limits.inverse_radius = InverseRadiusReset;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_SPEED:      limits.max_speed = csr_wdata[14:0];
               CSR_MAX_TURN_RATE:  limits.max_turn_rate = csr_wdata[14:0];
               CSR_SPEED_PER_TURN: limits.speed_per_turn = csr_wdata;
               CSR_HALF_TRACK:     limits.half_track = csr_wdata;
               CSR_INVERSE_RADIUS: limits.inverse_radius = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = wheel_rates(req_data, limits);
            if (listed_rates.size() != 0) begin
               listed = listed_rates.pop_front();
               if (listed.given) want = listed.rates;
            end
            pending_rates.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rates.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %0d / %0d", $time,
                        rsp_data.right_rate, rsp_data.left_rate);
               mismatches++;
            end else begin
               want = pending_rates.pop_front();
               if (rsp_data.right_rate !== want.right_rate) begin
                  $display("%0t: right_rate expected %0d actual %0d", $time,
                           want.right_rate, rsp_data.right_rate);
                  mismatches++;
               end
               if (rsp_data.left_rate !== want.left_rate) begin
                  $display("%0t: left_rate expected %0d actual %0d", $time,
                           want.left_rate, rsp_data.left_rate);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      bit writing;
      bit quiet;
      int ms, mt, spt, ht, ir;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      // reset defaults: 1 m/s, 4 rad/s, half track 0.25 m, radius 0.05 m
      plan.push_back(item_step(0, 0, 1, 0, 0));
      plan.push_back(item_step(4096, 0, 1, 81920, 81920));
      plan.push_back(item_step(-4096, 0, 1, -81920, -81920));
      plan.push_back(item_step(0, 16384, 1, 81920, -81920));
      plan.push_back(item_step(0, -16384, 1, -81920, 81920));
      plan.push_back(item_step(32767, -32768, 1, -163840, 163840));
      plan.push_back(item_step(-32768, 32767, 1, 163835, -163835));
      plan.push_back(item_step(4096, 8192));
      plan.push_back(item_step(-4096, -8192));
      plan.push_back(item_step(4095, 1));
      plan.push_back(item_step(1, 16383));
      plan.push_back(item_step(-1, -16383));
      plan.push_back(write_step(CSR_MAX_SPEED, 16'hFFFF));
      plan.push_back(write_step(CSR_MAX_TURN_RATE, 16'hFFFF));
      plan.push_back(write_step(CSR_SPEED_PER_TURN, 16'hFFFF));
      plan.push_back(write_step(CSR_HALF_TRACK, 16'hFFFF));
      plan.push_back(write_step(CSR_INVERSE_RADIUS, 16'hFFFF));
      plan.push_back(item_step(32767, 0));
      plan.push_back(item_step(-32768, 0));
      plan.push_back(item_step(32767, 32766));
      plan.push_back(item_step(-32768, -32766));
      plan.push_back(item_step(16384, -16384));
      // slope of zero: no speed reduction, right wheel rate saturates
      plan.push_back(write_step(CSR_SPEED_PER_TURN, 16'h0000));
      plan.push_back(item_step(32767, 32766));
      plan.push_back(item_step(-32768, -32766));
      plan.push_back(write_step(CSR_MAX_TURN_RATE, 16'h0000));
      plan.push_back(item_step(32767, 1));
      plan.push_back(write_step(CSR_MAX_SPEED, 16'h0000));
      plan.push_back(write_step(CSR_MAX_TURN_RATE, 16'h4000));
      plan.push_back(write_step(CSR_HALF_TRACK, 16'h0000));
      plan.push_back(item_step(-32768, 100));
      plan.push_back(write_step(CSR_INVERSE_RADIUS, 16'h0000));
      plan.push_back(item_step(32767, -32768, 1, 0, 0));
      plan.push_back(write_step(CsrLastIndex, 16'hFFFF));
      plan.push_back(write_step(CsrFirstUnmapped, 16'h1234));
      plan.push_back(item_step(-32768, 32767, 1, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == STEP_WRITE) begin
            if (!writing) wait_idle();
            writing = 1'b1;
            write_reg(plan[i].index, plan[i].value);
         end else begin
            if (writing) csr_valid <= 1'b0;
            writing = 1'b0;
            send_cmd(plan[i].cmd, plan[i].given, plan[i].rates);
            idle_gap(gap_len(1'b0));
         end
      end

      for (int phase = 0; phase < Phases; phase++) begin
         wait_idle();
         ms = pick_word($urandom_range(0, 1) ? 65535 : 8191);
         mt = pick_word($urandom_range(0, 1) ? 65535 : 16383);
         spt = $urandom_range(0, 4) != 0 ? consistent_slope(ms & 32'h7FFF, mt & 32'h7FFF)
                                         : pick_word(65535);
         ht = pick_word(65535);
         ir = pick_word($urandom_range(0, 1) ? 65535 : 8191);
         write_reg(CSR_MAX_SPEED, 16'(ms));
         write_reg(CSR_MAX_TURN_RATE, 16'(mt));
         write_reg(CSR_SPEED_PER_TURN, 16'(spt));
         write_reg(CSR_HALF_TRACK, 16'(ht));
         write_reg(CSR_INVERSE_RADIUS, 16'(ir));
         if ($urandom_range(0, 2) == 0) begin
            write_reg(3'($urandom_range(CsrFirstUnmapped, CsrLastIndex)),
                      16'($urandom_range(0, 65535)));
         end
         csr_valid <= 1'b0;
         ms = ms & 32'h7FFF;
         mt = mt & 32'h7FFF;
         quiet = $urandom_range(0, 3) == 0;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            send_cmd(random_cmd(ms, mt), 1'b0, '0);
            idle_gap(gap_len(quiet));
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
